FILE: src/ahc_pkg.sv
// Shared constants, codes and widths for the converter sample capture block.
package ahc_pkg;

   localparam int STORE_DEPTH = 4096;
   localparam int SAMPLE_BITS = 12;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int POS_BITS    = ADDR_BITS + 1;
   localparam int WORD_BITS   = 16;
   localparam int COUNT_BITS  = 20;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [COUNT_BITS-1:0] RESET_SKIP   = COUNT_BITS'(10000);
   localparam logic [COUNT_BITS-1:0] RESET_LENGTH = COUNT_BITS'(10000);

   // item actions
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_ARM    = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_CAPTURE_MODE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRETRIGGER_SKIP  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_HISTOGRAM_LENGTH = 2'd2;

   // capture modes
   localparam logic MODE_HISTOGRAM = 1'b0;
   localparam logic MODE_RECORD    = 1'b1;

   // store operations carried into the second stage
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_INCR  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // controller states
   localparam logic ST_CLEAR = 1'b0;
   localparam logic ST_RUN   = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           op;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] wdata;
      logic                 done;
      logic                 skipping;
   } stage_type;

endpackage

FILE: src/adc_histogram_capture.sv
// Top level of the converter sample capture engine: control, store pipeline, config.
//
// Usage:
//   Items enter on start/req_* and transfer at a rising edge where start is high
//   and busy is low. Action sample feeds one converter value, arm restarts a
//   capture, read returns one stored word at req_read_index.
//   Every item produces exactly one result on rsp_*, marked by rsp_valid for one
//   cycle; the receiver cannot stall, so results are never held.
//   The store read is registered with the item in stage one, and the modified
//   word and result go to the output register after it. Throughput is one item
//   per cycle while busy is low; a histogram increment hitting the same bin as
//   the previous item is forwarded from the last write, so no bubble is needed.
//   The first sample after an arm clears the store: busy rises while the sweep
//   writes zeros one word a cycle, stays high while the held sample is replayed,
//   and the result of that sample follows as for any other item.
//   Reset runs the same sweep, with busy high, so the store reads zero.
//   Configuration writes on csr_* have no handshake; write them only while idle.
//   Skip and length take effect at the next arm or the clear that follows; the
//   capture mode applies to the next sample.
module adc_histogram_capture (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_action,
   input  logic [11:0]                           req_sample,
   input  logic [11:0]                           req_read_index,
   output logic                                  rsp_valid,
   output logic [15:0]                           rsp_read_data,
   output logic                                  rsp_capture_done,
   output logic                                  rsp_skipping,
   input  logic                                  csr_write_enable,
   input  logic [ahc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [ahc_pkg::COUNT_BITS-1:0]        csr_data
);

   localparam int AB = ahc_pkg::ADDR_BITS;
   localparam int PB = ahc_pkg::POS_BITS;
   localparam int CB = ahc_pkg::COUNT_BITS;
   localparam int WB = ahc_pkg::WORD_BITS;
   localparam int SB = ahc_pkg::SAMPLE_BITS;

   // configuration
   logic          mode_ff;
   logic [CB-1:0] pretrigger_ff;
   logic [CB-1:0] length_ff;

   // capture state
   logic          state_ff, state_in;
   logic [AB-1:0] sweep_addr_ff, sweep_addr_in;
   logic          replay_pending_ff, replay_pending_in;
   logic          replay_go_ff, replay_go_in;
   logic [11:0]   pend_sample_ff, pend_sample_in;
   logic          clear_pending_ff, clear_pending_in;
   logic [CB-1:0] skip_left_ff, skip_left_in;
   logic [CB-1:0] count_left_ff, count_left_in;
   logic [PB-1:0] write_position_ff, write_position_in;
   logic          done_ff, done_in;

   // pipeline
   ahc_pkg::stage_type s1_ff, s1_in;
   logic          wr_valid_ff, wr_valid_in;
   logic [AB-1:0] wr_addr_ff;
   logic [WB-1:0] wr_data_ff;

   // results
   logic          rsp_valid_ff;
   logic [WB-1:0] rsp_read_data_ff;
   logic          rsp_done_ff;
   logic          rsp_skipping_ff;

   // item in stage zero
   logic          item_go;
   logic [1:0]    it_action;
   logic [11:0]   it_sample;
   logic [SB-1:0] it_value;
   logic [PB-1:0] wp_next;

   // store access
   logic          mem_we;
   logic [AB-1:0] mem_waddr;
   logic [WB-1:0] mem_wdata;
   logic [AB-1:0] mem_raddr;
   logic [WB-1:0] mem_q;
   logic [WB-1:0] fwd_word;

   assign busy      = (state_ff == ahc_pkg::ST_CLEAR) || replay_go_ff;
   assign item_go   = (start && !busy) || replay_go_ff;
   assign it_action = replay_go_ff ? ahc_pkg::ACT_SAMPLE : req_action;
   assign it_sample = replay_go_ff ? pend_sample_ff : req_sample;
   assign it_value  = SB'(it_sample);
   assign wp_next   = write_position_ff + PB'(1);

   // Stage zero: update counters and decide the store operation.
   always_comb begin
      state_in          = state_ff;
      sweep_addr_in     = sweep_addr_ff;
      replay_pending_in = replay_pending_ff;
      replay_go_in      = 1'b0;
      pend_sample_in    = pend_sample_ff;
      clear_pending_in  = clear_pending_ff;
      skip_left_in      = skip_left_ff;
      count_left_in     = count_left_ff;
      write_position_in = write_position_ff;
      done_in           = done_ff;
      s1_in             = '0;
      mem_raddr         = '0;

      unique case (state_ff)
         ahc_pkg::ST_CLEAR: begin
            // sweep one word a cycle; at the end replay the held sample, if one is pending
            sweep_addr_in = sweep_addr_ff + AB'(1);
            if (sweep_addr_ff == AB'(ahc_pkg::STORE_DEPTH - 1)) begin
               state_in          = ahc_pkg::ST_RUN;
               sweep_addr_in     = '0;
               replay_go_in      = replay_pending_ff;
               replay_pending_in = 1'b0;
            end
         end
         ahc_pkg::ST_RUN: begin
            if (item_go) begin
               s1_in.valid = 1'b1;
               case (it_action)
                  ahc_pkg::ACT_SAMPLE: begin
                     if (clear_pending_ff) begin
                        // hold the sample, clear the store, then replay it
                        s1_in.valid       = 1'b0;
                        state_in          = ahc_pkg::ST_CLEAR;
                        replay_pending_in = 1'b1;
                        pend_sample_in    = it_sample;
                        clear_pending_in  = 1'b0;
                        count_left_in     = length_ff;
                        done_in           = 1'b0;
                        write_position_in = '0;
                     end else if (skip_left_ff != '0) begin
                        skip_left_in = skip_left_ff - CB'(1);
                     end else if (mode_ff == ahc_pkg::MODE_HISTOGRAM) begin
                        if (count_left_ff != '0) begin
                           count_left_in = count_left_ff - CB'(1);
                           if (32'(it_value) < ahc_pkg::STORE_DEPTH) begin
                              s1_in.op   = ahc_pkg::OP_INCR;
                              s1_in.addr = AB'(it_value);
                              mem_raddr  = AB'(it_value);
                           end
                           if (count_left_ff == CB'(1)) begin
                              done_in = 1'b1;
                           end
                        end else begin
                           done_in = 1'b1;
                        end
                     end else begin
                        if (32'(write_position_ff) < ahc_pkg::STORE_DEPTH) begin
                           s1_in.op          = ahc_pkg::OP_WRITE;
                           s1_in.addr        = AB'(write_position_ff);
                           s1_in.wdata       = WB'(it_value);
                           write_position_in = wp_next;
                           if (32'(wp_next) >= ahc_pkg::STORE_DEPTH) begin
                              done_in = 1'b1;
                           end
                        end else begin
                           done_in = 1'b1;
                        end
                     end
                  end
                  ahc_pkg::ACT_ARM: begin
                     clear_pending_in  = 1'b1;
                     skip_left_in      = pretrigger_ff;
                     write_position_in = '0;
                  end
                  ahc_pkg::ACT_READ: begin
                     if (32'(req_read_index) < ahc_pkg::STORE_DEPTH) begin
                        s1_in.op   = ahc_pkg::OP_READ;
                        s1_in.addr = AB'(req_read_index);
                        mem_raddr  = AB'(req_read_index);
                     end
                  end
                  default: begin
                  end
               endcase
               s1_in.done     = done_in;
               s1_in.skipping = (skip_left_in != '0);
            end
         end
         default: begin
         end
      endcase
   end

   // Stage one: forward the last write if it hit the same word.
   assign fwd_word = (wr_valid_ff && (wr_addr_ff == s1_ff.addr)) ? wr_data_ff : mem_q;

   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = s1_ff.addr;
      mem_wdata   = s1_ff.wdata;
      wr_valid_in = 1'b0;
      if (state_ff == ahc_pkg::ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_addr_ff;
         mem_wdata = '0;
      end else if (s1_ff.valid) begin
         if (s1_ff.op == ahc_pkg::OP_INCR) begin
            mem_we    = 1'b1;
            mem_wdata = fwd_word + WB'(1);
         end else if (s1_ff.op == ahc_pkg::OP_WRITE) begin
            mem_we = 1'b1;
         end
         wr_valid_in = mem_we;
      end
   end

   ahc_ram #(
      .DEPTH (ahc_pkg::STORE_DEPTH),
      .WIDTH (WB)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (item_go),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= ahc_pkg::MODE_HISTOGRAM;
         pretrigger_ff     <= ahc_pkg::RESET_SKIP;
         length_ff         <= ahc_pkg::RESET_LENGTH;
         state_ff          <= ahc_pkg::ST_CLEAR;
         sweep_addr_ff     <= '0;
         replay_pending_ff <= 1'b0;
         replay_go_ff      <= 1'b0;
         clear_pending_ff  <= 1'b1;
         skip_left_ff      <= ahc_pkg::RESET_SKIP;
         count_left_ff     <= ahc_pkg::RESET_LENGTH;
         write_position_ff <= '0;
         done_ff           <= 1'b0;
         s1_ff.valid       <= 1'b0;
         wr_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               ahc_pkg::REG_CAPTURE_MODE:     mode_ff       <= csr_data[0];
               ahc_pkg::REG_PRETRIGGER_SKIP:  pretrigger_ff <= csr_data;
               ahc_pkg::REG_HISTOGRAM_LENGTH: length_ff     <= csr_data;
               default: begin
               end
            endcase
         end
         state_ff          <= state_in;
         sweep_addr_ff     <= sweep_addr_in;
         replay_pending_ff <= replay_pending_in;
         replay_go_ff      <= replay_go_in;
         clear_pending_ff  <= clear_pending_in;
         skip_left_ff      <= skip_left_in;
         count_left_ff     <= count_left_in;
         write_position_ff <= write_position_in;
         done_ff           <= done_in;
         s1_ff             <= s1_in;
         wr_valid_ff       <= wr_valid_in;
         rsp_valid_ff      <= s1_ff.valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_sample_ff   <= pend_sample_in;
      wr_addr_ff       <= mem_waddr;
      wr_data_ff       <= mem_wdata;
      rsp_read_data_ff <= (s1_ff.op == ahc_pkg::OP_READ) ? fwd_word : '0;
      rsp_done_ff      <= s1_ff.done;
      rsp_skipping_ff  <= s1_ff.skipping;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_capture_done = rsp_done_ff;
   assign rsp_skipping     = rsp_skipping_ff;

endmodule

FILE: src/ahc_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ahc_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
